/* rtl/bpg_pkg.sv */
// ----------------------------------------------------------------------------
// bpg_pkg: shared types and constants of the burst pulse generator
// payload structs, register map, operation codes and the packed-field helper
// ----------------------------------------------------------------------------
package bpg_pkg;

  localparam int CHANNELS    = 4;
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_W       = 64;
  localparam int ADDR_W      = 5;
  localparam int CH_W        = 2;
  localparam int MASK_W      = 4;

  // packed settings padded with zeros so a field past bit 63 reads as zero
  localparam int FIELD_PAD_W = CHANNELS * COUNT_WIDTH + CFG_W;
  localparam int FIELD_IDX_W = $clog2(FIELD_PAD_W);

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    REG_ON_TIMES     = 2'd0,
    REG_OFF_TIMES    = 2'd1,
    REG_BURST_LIMITS = 2'd2,
    REG_STOP_LEVELS  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] channel;
    logic            enable_value;
  } bpg_in_t;

  typedef struct packed {
    logic [MASK_W-1:0] pin_levels;
    logic [MASK_W-1:0] enabled_mask;
  } bpg_out_t;

  function automatic logic [COUNT_WIDTH-1:0] field_of(input logic [CFG_W-1:0] word,
                                                      input int ch);
    logic [FIELD_PAD_W-1:0] padded;
    padded = {{(FIELD_PAD_W-CFG_W){1'b0}}, word};
    return padded[FIELD_IDX_W'(ch*COUNT_WIDTH) +: COUNT_WIDTH];
  endfunction

endpackage

/* rtl/burst_pulse_generator_core.sv */
// ----------------------------------------------------------------------------
// burst_pulse_generator_core: four-channel burst pulse generator
// tick and enable transactions in, pin levels and enable mask out
// ----------------------------------------------------------------------------
// Each input transaction is either a timer tick, which advances every running
// channel through its high phase (on_times ticks), low phase (off_times ticks)
// and pulse count (burst_limits, zero for endless), or an enable write to one
// channel. The channel state is updated at the edge the transaction is
// accepted and the resulting pin levels and enable mask land in the output
// register at that same edge, and the block accepts a new transaction every
// cycle as long as the output register is empty or being drained; the only
// limit is the single output register. A channel that finishes its burst or
// is disabled drives its stop_levels bit. Settings are written over the APB
// port at 8-byte spacing (on, off, limits, stop levels) and should only be
// changed while no transaction is in flight.
module burst_pulse_generator_core
  import bpg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready,
  // command stream
  input  logic              in_valid,
  output logic              in_ready,
  input  bpg_in_t           in_data,
  // status stream
  output logic              out_valid,
  input  logic              out_ready,
  output bpg_out_t          out_data
);

  // settings
  logic [CFG_W-1:0]  on_times;
  logic [CFG_W-1:0]  off_times;
  logic [CFG_W-1:0]  burst_limits;
  logic [MASK_W-1:0] stop_levels;

  // channel state
  logic [CHANNELS-1:0]    phase_low, phase_low_next;
  logic [CHANNELS-1:0]    running, running_next;
  logic [CHANNELS-1:0]    pin_level, pin_level_next;
  logic [COUNT_WIDTH-1:0] tick_count [CHANNELS];
  logic [COUNT_WIDTH-1:0] tick_count_next [CHANNELS];
  logic [COUNT_WIDTH-1:0] pulse_count [CHANNELS];
  logic [COUNT_WIDTH-1:0] pulse_count_next [CHANNELS];

  logic     in_fire;
  logic     cfg_write;
  reg_idx_t cfg_idx;
  bpg_out_t result_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:3]);

  // output register frees up when empty or when drained this cycle
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      on_times     <= '0;
      off_times    <= '0;
      burst_limits <= '0;
      stop_levels  <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_ON_TIMES:     on_times     <= pwdata;
        REG_OFF_TIMES:    off_times    <= pwdata;
        REG_BURST_LIMITS: burst_limits <= pwdata;
        REG_STOP_LEVELS:  stop_levels  <= pwdata[MASK_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ON_TIMES:     prdata = on_times;
      REG_OFF_TIMES:    prdata = off_times;
      REG_BURST_LIMITS: prdata = burst_limits;
      REG_STOP_LEVELS:  prdata = {{(CFG_W-MASK_W){1'b0}}, stop_levels};
      default:          prdata = '0;
    endcase
  end

  // channel update for the accepted transaction
  always_comb begin
    logic [COUNT_WIDTH:0] tick_inc;
    logic [COUNT_WIDTH:0] pulse_inc;
    logic [COUNT_WIDTH-1:0] limit;
    phase_low_next = phase_low;
    running_next   = running;
    pin_level_next = pin_level;
    tick_count_next  = tick_count;
    pulse_count_next = pulse_count;
    tick_inc  = '0;
    pulse_inc = '0;
    limit     = '0;
    if (in_fire) begin
      if (in_data.op == OP_TICK) begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          if (running[ch]) begin
            tick_inc = {1'b0, tick_count[ch]} + 1'b1;
            if (!phase_low[ch]) begin
              // high phase
              pin_level_next[ch] = 1'b1;
              if (tick_inc >= {1'b0, field_of(on_times, ch)}) begin
                phase_low_next[ch]  = 1'b1;
                tick_count_next[ch] = '0;
              end else begin
                tick_count_next[ch] = tick_inc[COUNT_WIDTH-1:0];
              end
            end else begin
              // low phase, end of a pulse once off count is reached
              pin_level_next[ch] = 1'b0;
              if (tick_inc >= {1'b0, field_of(off_times, ch)}) begin
                limit     = field_of(burst_limits, ch);
                pulse_inc = {1'b0, pulse_count[ch]} + 1'b1;
                phase_low_next[ch]  = 1'b0;
                tick_count_next[ch] = '0;
                if ((limit != '0) && (pulse_inc >= {1'b0, limit})) begin
                  // burst done: park the channel at its stop level
                  running_next[ch]     = 1'b0;
                  pulse_count_next[ch] = '0;
                  pin_level_next[ch]   = stop_levels[ch];
                end else begin
                  // count the pulse; endless bursts wrap the pulse count
                  pulse_count_next[ch] = pulse_inc[COUNT_WIDTH-1:0];
                end
              end else begin
                tick_count_next[ch] = tick_inc[COUNT_WIDTH-1:0];
              end
            end
          end
        end
      end else begin
        if (int'(in_data.channel) < CHANNELS) begin
          if (in_data.enable_value) begin
            // phase, counters and pin are kept
            running_next[in_data.channel] = 1'b1;
          end else begin
            running_next[in_data.channel]     = 1'b0;
            phase_low_next[in_data.channel]   = 1'b0;
            tick_count_next[in_data.channel]  = '0;
            pulse_count_next[in_data.channel] = '0;
            pin_level_next[in_data.channel]   = stop_levels[in_data.channel];
          end
        end
      end
    end
  end

  // status seen after the update, channels past the mask width dropped
  always_comb begin
    result_next = '0;
    for (int ch = 0; ch < CHANNELS && ch < MASK_W; ch++) begin
      result_next.pin_levels[ch]   = pin_level_next[ch];
      result_next.enabled_mask[ch] = running_next[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_low <= '0;
      running   <= '0;
      pin_level <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        tick_count[ch]  <= '0;
        pulse_count[ch] <= '0;
      end
    end else begin
      phase_low   <= phase_low_next;
      running     <= running_next;
      pin_level   <= pin_level_next;
      tick_count  <= tick_count_next;
      pulse_count <= pulse_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result_next;
    end
  end

  // checks

  // a stopped channel always sits in the high phase with cleared counters
  logic [CHANNELS-1:0] idle_dirty;
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      idle_dirty[ch] = !running[ch] &&
                       (phase_low[ch] || (tick_count[ch] != '0) || (pulse_count[ch] != '0));
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    idle_dirty == '0)
    else $error("stopped channel holds phase or count state");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted transaction produced no result");

  a_mask_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.enabled_mask == result_next.enabled_mask) || in_fire)
    else $error("pending enable mask disagrees with channel state");

endmodule
